// ===== sv/tff_pkg.sv =====
// ----------------------------------------------------------------------------
// tff_pkg
// shared types and constants of the tolerance flood fill block
// ----------------------------------------------------------------------------
package tff_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int COORD_W     = 8;
    localparam int DIM_W       = 9;
    localparam int INDEX_W     = 16;
    localparam int DEPTH_W     = 17;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

    // request codes
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_FILL  = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // response kinds
    localparam logic RESP_READ = 1'b0;
    localparam logic RESP_FILL = 1'b1;

    // configuration register indexes
    localparam logic [2:0] CFG_WIDTH     = 3'd0;
    localparam logic [2:0] CFG_HEIGHT    = 3'd1;
    localparam logic [2:0] CFG_SEED_X    = 3'd2;
    localparam logic [2:0] CFG_SEED_Y    = 3'd3;
    localparam logic [2:0] CFG_FILL_RGBA = 3'd4;
    localparam logic [2:0] CFG_TOL_SQ    = 3'd5;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] pixel_index;
        logic [31:0] pixel_rgba;
    } tff_req_t;

    typedef struct packed {
        logic        resp_kind;
        logic [31:0] read_rgba;
        logic [16:0] filled_count;
    } tff_resp_t;

endpackage

// ===== sv/tolerance_flood_fill.sv =====
// ----------------------------------------------------------------------------
// tolerance_flood_fill
// rgba image store with a stack driven four-connected tolerance flood fill
// ----------------------------------------------------------------------------
// A write returns nothing; a new item can follow at once. A read returns its
// pixel through the registered pixel output and the result register. A fill
// first sweeps all 65536 visited-map entries at one entry a cycle, reads the
// seed (S_SEEDRD, S_SEED) and walks the stack: each popped entry passes S_POP,
// S_INDEX, S_PIXRD and S_JOIN; each pixel that joins checks its four neighbors
// in S_NB plus S_NBCHK per in-image neighbor; S_POP on the empty stack and
// S_DONE end it. All of this is set by the single port of each of the three
// memories (pixels, visited marks, stack). The result strobe is high for one
// cycle and cannot be held off; busy stays high until a fill or read is done.
module tolerance_flood_fill (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tff_pkg::tff_req_t req,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    output logic              resp_valid,
    output tff_pkg::tff_resp_t resp
);
    import tff_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_READ   = 4'd1;
    localparam logic [3:0] S_CLEAR  = 4'd2;
    localparam logic [3:0] S_SEEDRD = 4'd3;
    localparam logic [3:0] S_SEED   = 4'd4;
    localparam logic [3:0] S_POP    = 4'd5;
    localparam logic [3:0] S_INDEX  = 4'd6;
    localparam logic [3:0] S_PIXRD  = 4'd7;
    localparam logic [3:0] S_JOIN   = 4'd8;
    localparam logic [3:0] S_NB     = 4'd9;
    localparam logic [3:0] S_NBCHK  = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    // configuration
    logic [DIM_W-1:0]   width_reg, height_reg;
    logic [COORD_W-1:0] seed_x_reg, seed_y_reg;
    logic [31:0]        fill_rgba_reg;
    logic [17:0]        tol_sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= DIM_W'(MAX_WIDTH);
            height_reg    <= DIM_W'(MAX_HEIGHT);
            seed_x_reg    <= '0;
            seed_y_reg    <= '0;
            fill_rgba_reg <= 32'd255;
            tol_sq_reg    <= 18'd5852;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDTH:     width_reg     <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT:    height_reg    <= cfg_data[DIM_W-1:0];
                CFG_SEED_X:    seed_x_reg    <= cfg_data[COORD_W-1:0];
                CFG_SEED_Y:    seed_y_reg    <= cfg_data[COORD_W-1:0];
                CFG_FILL_RGBA: fill_rgba_reg <= cfg_data;
                CFG_TOL_SQ:    tol_sq_reg    <= cfg_data[17:0];
                default:       ;
            endcase
        end
    end

    // clamped image size and seed
    logic [DIM_W-1:0]   w_eff, h_eff;
    logic [COORD_W-1:0] sx_eff, sy_eff;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = DIM_W'(1);
        else if (width_reg > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = DIM_W'(1);
        else if (height_reg > DIM_W'(MAX_HEIGHT))
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;
        sx_eff = ({1'b0, seed_x_reg} < w_eff) ? seed_x_reg : COORD_W'(w_eff - 9'd1);
        sy_eff = ({1'b0, seed_y_reg} < h_eff) ? seed_y_reg : COORD_W'(h_eff - 9'd1);
    end

    // memories
    logic [31:0]        pix_mem [STORE_DEPTH];
    logic               pix_we;
    logic [INDEX_W-1:0] pix_addr;
    logic [31:0]        pix_wdata, pix_q;

    always_ff @(posedge clk)
    begin
        if (pix_we)
            pix_mem[pix_addr] <= pix_wdata;
        pix_q <= pix_mem[pix_addr];
    end

    logic               vis_mem [STORE_DEPTH];
    logic               vis_we, vis_wdata, vis_q;
    logic [INDEX_W-1:0] vis_addr;

    always_ff @(posedge clk)
    begin
        if (vis_we)
            vis_mem[vis_addr] <= vis_wdata;
        vis_q <= vis_mem[vis_addr];
    end

    logic [INDEX_W-1:0] stk_mem [STORE_DEPTH];
    logic               stk_we;
    logic [INDEX_W-1:0] stk_addr, stk_wdata, stk_q;

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_addr] <= stk_wdata;
        stk_q <= stk_mem[stk_addr];
    end

    // control and datapath registers
    logic [3:0]         state_reg, state_next;
    logic [INDEX_W-1:0] addr_reg, addr_next;     // clear sweep or current pixel index
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [23:0]        target_reg, target_next;
    logic [16:0]        count_reg, count_next;
    logic [COORD_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [1:0]         nb_reg, nb_next;
    logic [INDEX_W-1:0] nb_idx_reg, nb_idx_next;
    logic [INDEX_W-1:0] nb_xy_reg, nb_xy_next;   // stack entries hold {row, column}
    logic               rv_reg, rv_next;
    tff_resp_t          resp_reg, resp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            depth_reg  <= '0;
            target_reg <= '0;
            rv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            depth_reg  <= depth_next;
            target_reg <= target_next;
            rv_reg     <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        count_reg  <= count_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        nb_reg     <= nb_next;
        nb_idx_reg <= nb_idx_next;
        nb_xy_reg  <= nb_xy_next;
        resp_reg   <= resp_next;
    end

    // seed and popped pixel index: row times width plus column
    logic [16:0] row_mul;
    logic [7:0]  dr, dg, db;
    logic [17:0] dist_sq;
    logic        nb_ok;
    logic [INDEX_W-1:0] nb_idx_c;
    logic [COORD_W-1:0] nb_x_c, nb_y_c;

    always_comb
    begin
        row_mul = 17'(cy_reg * w_eff) + 17'(cx_reg);
        dr = (pix_q[7:0] > target_reg[7:0]) ? pix_q[7:0] - target_reg[7:0]
                                            : target_reg[7:0] - pix_q[7:0];
        dg = (pix_q[15:8] > target_reg[15:8]) ? pix_q[15:8] - target_reg[15:8]
                                              : target_reg[15:8] - pix_q[15:8];
        db = (pix_q[23:16] > target_reg[23:16]) ? pix_q[23:16] - target_reg[23:16]
                                                : target_reg[23:16] - pix_q[23:16];
        dist_sq = 18'(dr * dr) + 18'(dg * dg) + 18'(db * db);

        nb_x_c   = cx_reg;
        nb_y_c   = cy_reg;
        nb_ok    = 1'b0;
        nb_idx_c = addr_reg;
        case (nb_reg)
            2'd0:
            begin
                nb_ok    = (cx_reg != '0);
                nb_x_c   = cx_reg - 8'd1;
                nb_idx_c = addr_reg - 16'd1;
            end
            2'd1:
            begin
                nb_ok    = ({1'b0, cx_reg} + 9'd1 < w_eff);
                nb_x_c   = cx_reg + 8'd1;
                nb_idx_c = addr_reg + 16'd1;
            end
            2'd2:
            begin
                nb_ok    = (cy_reg != '0);
                nb_y_c   = cy_reg - 8'd1;
                nb_idx_c = addr_reg - INDEX_W'(w_eff);
            end
            default:
            begin
                nb_ok    = ({1'b0, cy_reg} + 9'd1 < h_eff);
                nb_y_c   = cy_reg + 8'd1;
                nb_idx_c = addr_reg + INDEX_W'(w_eff);
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        depth_next  = depth_reg;
        target_next = target_reg;
        count_next  = count_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        nb_next     = nb_reg;
        nb_idx_next = nb_idx_reg;
        nb_xy_next  = nb_xy_reg;
        rv_next     = 1'b0;
        resp_next   = resp_reg;
        pix_we      = 1'b0;
        pix_addr    = addr_reg;
        pix_wdata   = fill_rgba_reg;
        vis_we      = 1'b0;
        vis_addr    = addr_reg;
        vis_wdata   = 1'b0;
        stk_we      = 1'b0;
        stk_addr    = INDEX_W'(depth_reg - 17'd1);
        stk_wdata   = nb_xy_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                pix_addr  = req.pixel_index;
                pix_wdata = req.pixel_rgba;
                if (start)
                begin
                    case (req.req_type)
                        REQ_WRITE: pix_we = 1'b1;
                        REQ_READ:  state_next = S_READ;
                        REQ_FILL:
                        begin
                            addr_next  = '0;
                            count_next = '0;
                            cx_next    = sx_eff;
                            cy_next    = sy_eff;
                            state_next = S_CLEAR;
                        end
                        default:   ;
                    endcase
                end
            end
            S_READ:
            begin
                rv_next    = 1'b1;
                resp_next  = '{resp_kind: RESP_READ, read_rgba: pix_q, filled_count: '0};
                state_next = S_IDLE;
            end
            S_CLEAR:
            begin
                vis_we    = 1'b1;
                addr_next = addr_reg + 16'd1;
                if (addr_reg == '1)
                    state_next = S_SEEDRD;
            end
            S_SEEDRD:
            begin
                addr_next  = INDEX_W'(row_mul);
                pix_addr   = INDEX_W'(row_mul);
                state_next = S_SEED;
            end
            S_SEED:
            begin
                // target is a snapshot of the seed; seed marked and pushed
                target_next = pix_q[23:0];
                vis_we      = 1'b1;
                vis_wdata   = 1'b1;
                stk_we      = 1'b1;
                stk_addr    = '0;
                stk_wdata   = {cy_reg, cx_reg};
                depth_next  = 17'd1;
                state_next  = S_POP;
            end
            S_POP:
            begin
                if (depth_reg == '0)
                    state_next = S_DONE;
                else
                begin
                    depth_next = depth_reg - 17'd1;
                    state_next = S_INDEX;
                end
            end
            S_INDEX:
            begin
                cy_next    = stk_q[15:8];
                cx_next    = stk_q[7:0];
                state_next = S_PIXRD;
            end
            S_PIXRD:
            begin
                addr_next  = INDEX_W'(row_mul);
                pix_addr   = INDEX_W'(row_mul);
                state_next = S_JOIN;
            end
            S_JOIN:
            begin
                if (dist_sq <= tol_sq_reg)
                begin
                    pix_we = 1'b1;
                    if (count_reg != '1)
                        count_next = count_reg + 17'd1;
                    nb_next    = 2'd0;
                    state_next = S_NB;
                end
                else
                    state_next = S_POP;
            end
            S_NB:
            begin
                vis_addr    = nb_idx_c;
                nb_idx_next = nb_idx_c;
                nb_xy_next  = {nb_y_c, nb_x_c};
                if (nb_ok)
                    state_next = S_NBCHK;
                else
                begin
                    nb_next = nb_reg + 2'd1;
                    if (nb_reg == 2'd3)
                        state_next = S_POP;
                end
            end
            S_NBCHK:
            begin
                vis_addr = nb_idx_reg;
                if (!vis_q)
                begin
                    vis_we     = 1'b1;
                    vis_wdata  = 1'b1;
                    stk_we     = 1'b1;
                    stk_addr   = INDEX_W'(depth_reg);
                    depth_next = depth_reg + 17'd1;
                end
                nb_next    = nb_reg + 2'd1;
                state_next = (nb_reg == 2'd3) ? S_POP : S_NB;
            end
            S_DONE:
            begin
                rv_next    = 1'b1;
                resp_next  = '{resp_kind: RESP_FILL, read_rgba: '0, filled_count: count_reg};
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign busy       = (state_reg != S_IDLE);
    assign resp_valid = rv_reg;
    assign resp       = resp_reg;

endmodule

// ===== sv/tff_checker.sv =====
// ----------------------------------------------------------------------------
// tff_checker
// port level checks of the tolerance flood fill block
// ----------------------------------------------------------------------------
module tff_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input tff_pkg::tff_req_t  req,
    input logic               resp_valid,
    input tff_pkg::tff_resp_t resp
);
    import tff_pkg::*;

    // a write transfer never makes the block busy
    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req.req_type == REQ_WRITE |=> !busy)
        else $error("busy after write");

    // results never come back to back
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid |=> !resp_valid)
        else $error("back to back results");

    a_read_count: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && resp.resp_kind == RESP_READ |-> resp.filled_count == '0)
        else $error("read with nonzero count");

    a_fill_data: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && resp.resp_kind == RESP_FILL |-> resp.read_rgba == '0)
        else $error("fill with nonzero data");

endmodule

bind tolerance_flood_fill tff_checker u_tff_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .resp_valid (resp_valid),
    .resp       (resp)
);
